>>> design/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg: shared types and constants of the gap buffer engine
// Store geometry, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gbe_pkg;

	// Store geometry
	localparam int CAPACITY = 4096;
	localparam int MAX_READ = 64;
	localparam int AW       = $clog2(CAPACITY);       // physical index width
	localparam int LW       = 13;                     // length / cursor field width
	localparam int CW       = 7;                      // count field width

	localparam logic [LW-1:0] CAP_LEN   = LW'(CAPACITY);
	localparam logic [LW:0]   CAP_EXT   = (LW+1)'(CAPACITY);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_READ);

	// Operation codes
	typedef enum logic [2:0] {
		K_INSERT   = 3'd0,
		K_MOVE_REL = 3'd1,
		K_MOVE_ABS = 3'd2,
		K_READ     = 3'd3,
		K_CLEAR    = 3'd4
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT,
		S_MV_RD,
		S_MV_WR,
		S_RD_ADDR,
		S_RD_DATA
	} state_t;

endpackage

`default_nettype wire

>>> design/gbe_in_if.sv
// ----------------------------------------------------------------------------
// gbe_in_if: command channel of the gap buffer engine
// Valid/ready channel carrying one operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbe_in_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               kind;
	logic [7:0]               data_byte;
	logic signed [13:0]       delta;
	logic [gbe_pkg::LW-1:0]   position;
	logic [11:0]              offset;
	logic [gbe_pkg::CW-1:0]   count;

	modport source (output valid, kind, data_byte, delta, position, offset, count,
		input ready);
	modport sink (input valid, kind, data_byte, delta, position, offset, count,
		output ready);
endinterface

`default_nettype wire

>>> design/gbe_out_if.sv
// ----------------------------------------------------------------------------
// gbe_out_if: result channel of the gap buffer engine
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbe_out_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [7:0]               read_byte;
	logic                     last;
	logic [gbe_pkg::LW-1:0]   cursor_pos;
	logic [gbe_pkg::LW-1:0]   text_length;

	modport source (output valid, status, read_byte, last, cursor_pos, text_length,
		input ready);
	modport sink (input valid, status, read_byte, last, cursor_pos, text_length,
		output ready);
endinterface

`default_nettype wire

>>> design/gbe_ram.sv
// ----------------------------------------------------------------------------
// gbe_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/gap_buffer_engine_core.sv
// ----------------------------------------------------------------------------
// gap_buffer_engine_core: gap buffer text store
// Insert at the cursor, cursor moves that copy bytes across the gap, ranged
// reads that skip the gap, and clear, run by a sequencer over one byte store.
//
//   channel | dir | content
//   --------+-----+----------------------------------------------------------
//   req     | in  | kind, data_byte, delta, position, offset, count
//   rsp     | out | status, read_byte, last, cursor_pos, text_length
//
// Insert, clear and refused operations: the transfer, then the result load.
// Cursor move by d bytes: each byte is one read then one write on the single
// store port pair. Read of n bytes: a lookup then a hand-off for each byte.
// req.ready is high only while the sequencer is idle; a result waiting in the
// output register stalls the sequencer only when the next result is due.
// Reset clears cursor, length and control; store contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_engine_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gbe_in_if.sink     req,
	gbe_out_if.source  rsp
);

	localparam int AW = gbe_pkg::AW;
	localparam int LW = gbe_pkg::LW;
	localparam int CW = gbe_pkg::CW;

	gbe_pkg::state_t  state_q, state_d;
	gbe_pkg::status_t pend_q, pend_d;
	logic [LW-1:0]    cursor_q, cursor_d;
	logic [LW-1:0]    length_q, length_d;
	logic [LW-1:0]    target_q, target_d;
	logic [LW-1:0]    ptr_q, ptr_d;
	logic [CW-1:0]    cnt_q, cnt_d;

	// Output register
	logic             ovalid_q;
	gbe_pkg::status_t ostatus_q;
	logic [7:0]       obyte_q;
	logic             olast_q;
	logic [LW-1:0]    ocursor_q, olen_q;

	logic             out_free, out_load;
	gbe_pkg::status_t load_status;
	logic [7:0]       load_byte;
	logic             load_last;

	// Store port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// Address arithmetic
	logic [LW:0]          gap_top;     // first physical index above the gap
	logic [AW-1:0]        upper, upper_m1;
	logic [LW:0]          ptr_skip;
	logic [AW-1:0]        rd_phys;
	logic signed [LW+1:0] rel_sum;
	logic [LW-1:0]        rd_end;
	logic                 move_left;

	gbe_ram #(
		.WIDTH (8),
		.DEPTH (gbe_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign gap_top  = gbe_pkg::CAP_EXT - {1'b0, length_q} + {1'b0, cursor_q};
	assign upper    = gap_top[AW-1:0];
	assign upper_m1 = upper - AW'(1);
	assign ptr_skip = {1'b0, ptr_q} + gbe_pkg::CAP_EXT - {1'b0, length_q};
	assign rd_phys  = (ptr_q < cursor_q) ? ptr_q[AW-1:0] : ptr_skip[AW-1:0];
	assign rel_sum  = $signed({2'b00, cursor_q}) + (LW+2)'(req.delta);
	assign rd_end   = LW'({1'b0, req.offset}) + LW'(req.count);
	assign move_left = target_q < cursor_q;

	assign out_free = !ovalid_q || rsp.ready;
	assign req.ready = (state_q == gbe_pkg::S_IDLE);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gbe_pkg::S_IDLE;
			cursor_q <= '0;
			length_q <= '0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			length_q <= length_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		pend_q   <= pend_d;
		target_q <= target_d;
		ptr_q    <= ptr_d;
		cnt_q    <= cnt_d;
	end

	// Next state, store access and result loading
	always_comb begin
		state_d     = state_q;
		pend_d      = pend_q;
		cursor_d    = cursor_q;
		length_d    = length_q;
		target_d    = target_q;
		ptr_d       = ptr_q;
		cnt_d       = cnt_q;
		ram_we      = 1'b0;
		ram_waddr   = cursor_q[AW-1:0];
		ram_wdata   = ram_rdata;
		ram_re      = 1'b0;
		ram_raddr   = rd_phys;
		out_load    = 1'b0;
		load_status = pend_q;
		load_byte   = '0;
		load_last   = 1'b1;

		unique case (state_q)
			gbe_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = gbe_pkg::S_EMIT;
					pend_d  = gbe_pkg::ST_OK;
					case (gbe_pkg::kind_t'(req.kind))
						gbe_pkg::K_INSERT: begin
							if (length_q == gbe_pkg::CAP_LEN) begin
								pend_d = gbe_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = req.data_byte;
								cursor_d  = cursor_q + LW'(1);
								length_d  = length_q + LW'(1);
							end
						end
						gbe_pkg::K_MOVE_REL: begin
							if (rel_sum[LW+1] || (rel_sum[LW:0] > {1'b0, length_q})) begin
								pend_d = gbe_pkg::ST_RANGE;
							end else begin
								target_d = rel_sum[LW-1:0];
								state_d  = gbe_pkg::S_MV_RD;
							end
						end
						gbe_pkg::K_MOVE_ABS: begin
							if (req.position > length_q) begin
								pend_d = gbe_pkg::ST_RANGE;
							end else begin
								target_d = req.position;
								state_d  = gbe_pkg::S_MV_RD;
							end
						end
						gbe_pkg::K_READ: begin
							if ((req.count == '0) || (req.count > gbe_pkg::MAX_COUNT) ||
							    (rd_end > length_q)) begin
								pend_d = gbe_pkg::ST_RANGE;
							end else begin
								ptr_d   = LW'(req.offset);
								cnt_d   = req.count;
								state_d = gbe_pkg::S_RD_ADDR;
							end
						end
						gbe_pkg::K_CLEAR: begin
							cursor_d = '0;
							length_d = '0;
						end
						default: begin
							pend_d = gbe_pkg::ST_RANGE;
						end
					endcase
				end
			end

			// Single result for everything but a good read
			gbe_pkg::S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = gbe_pkg::S_IDLE;
				end
			end

			// Move: fetch the byte that crosses the gap next
			gbe_pkg::S_MV_RD: begin
				if (cursor_q == target_q) begin
					state_d = gbe_pkg::S_EMIT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = move_left ? (cursor_q[AW-1:0] - AW'(1)) : upper;
					state_d   = gbe_pkg::S_MV_WR;
				end
			end

			// Move: drop it on the other side and shift the cursor one place
			gbe_pkg::S_MV_WR: begin
				ram_we = 1'b1;
				if (move_left) begin
					ram_waddr = upper_m1;
					cursor_d  = cursor_q - LW'(1);
				end else begin
					ram_waddr = cursor_q[AW-1:0];
					cursor_d  = cursor_q + LW'(1);
				end
				state_d = gbe_pkg::S_MV_RD;
			end

			// Read: look up the physical index of the current logical byte
			gbe_pkg::S_RD_ADDR: begin
				ram_re  = 1'b1;
				state_d = gbe_pkg::S_RD_DATA;
			end

			// Read: hand the byte to the output register
			gbe_pkg::S_RD_DATA: begin
				if (out_free) begin
					out_load    = 1'b1;
					load_status = gbe_pkg::ST_OK;
					load_byte   = ram_rdata;
					load_last   = (cnt_q == CW'(1));
					cnt_d       = cnt_q - CW'(1);
					ptr_d       = ptr_q + LW'(1);
					state_d     = load_last ? gbe_pkg::S_IDLE : gbe_pkg::S_RD_ADDR;
				end
			end

			default: begin
				state_d = gbe_pkg::S_IDLE;
			end
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			ostatus_q <= load_status;
			obyte_q   <= load_byte;
			olast_q   <= load_last;
			ocursor_q <= cursor_q;
			olen_q    <= length_q;
		end
	end

	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ostatus_q;
	assign rsp.read_byte   = obyte_q;
	assign rsp.last        = olast_q;
	assign rsp.cursor_pos  = ocursor_q;
	assign rsp.text_length = olen_q;

endmodule

`default_nettype wire

>>> design/gbe_checker.sv
// ----------------------------------------------------------------------------
// gbe_checker: port-level checks for the gap buffer engine
// Watches both channels and flags results the store could never produce.
// ----------------------------------------------------------------------------
`default_nettype none

module gbe_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [1:0]             status,
	input wire logic [7:0]             read_byte,
	input wire logic                   last,
	input wire logic [gbe_pkg::LW-1:0] cursor_pos,
	input wire logic [gbe_pkg::LW-1:0] text_length
);

	// A waiting result stays until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// One operation at a time: no command taken right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while the previous one is in work");

	// Cursor inside the text, text inside the store
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_pos <= text_length) && (text_length <= gbe_pkg::CAP_LEN))
		else $error("cursor or length out of bounds");

	// Errors come alone, with no data
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != gbe_pkg::ST_OK) |-> last && (read_byte == 8'd0))
		else $error("error result not final or carries data");

endmodule

bind gap_buffer_engine_core gbe_checker u_gbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.read_byte   (rsp.read_byte),
	.last        (rsp.last),
	.cursor_pos  (rsp.cursor_pos),
	.text_length (rsp.text_length)
);

`default_nettype wire

>>> verif/gap_buffer_engine_core_test.sv
// ----------------------------------------------------------------------------
// gap_buffer_engine_core_test: self-checking bench of the gap buffer engine
// Drives directed and random operations, including refused moves and reads
// at the edges of the text, into the command channel. A gap-buffer model of
// the text predicts every result transfer, and each one is checked in order.
// ----------------------------------------------------------------------------
module gap_buffer_engine_core_test;

	localparam int STALL_LIMIT = 50000;  // cycles without any transfer
	localparam int MAX_REPORTS = 50;

	typedef struct {
		logic [2:0]                 kind;
		logic [7:0]                 data_byte;
		logic signed [13:0]         delta;
		logic [gbe_pkg::LW-1:0]     position;
		logic [11:0]                offset;
		logic [gbe_pkg::CW-1:0]     count;
	} command_t;

	typedef struct {
		gbe_pkg::status_t           status;
		logic [7:0]                 read_byte;
		logic                       last;
		logic [gbe_pkg::LW-1:0]     cursor_pos;
		logic [gbe_pkg::LW-1:0]     text_length;
	} result_t;

	// Gap-buffer model of the text and queue of predicted results
	class gap_text_model;
		logic [7:0] store_mem [gbe_pkg::CAPACITY];
		int         cursor;
		int         text_len;
		result_t    pending_results [$];
		int         errors;

		function new();
			foreach (store_mem[i])
				store_mem[i] = 8'h00;
			cursor = 0;
			text_len = 0;
			errors = 0;
		endfunction

		// Move the gap so that it starts at logical position target
		function void shift_gap(int target);
			int upper;
			int k;
			upper = gbe_pkg::CAPACITY - (text_len - cursor);
			if (target < cursor) begin
				k = cursor - target;
				for (int i = k - 1; i >= 0; i--)
					store_mem[upper - k + i] = store_mem[target + i];
			end else if (target > cursor) begin
				k = target - cursor;
				for (int i = 0; i < k; i++)
					store_mem[cursor + i] = store_mem[upper + i];
			end
			cursor = target;
		endfunction

		function logic [7:0] byte_at(int logical);
			int phys;
			phys = (logical < cursor) ? logical : logical + (gbe_pkg::CAPACITY - text_len);
			return (phys >= gbe_pkg::CAPACITY) ? 8'h00 : store_mem[phys];
		endfunction

		function result_t status_only(gbe_pkg::status_t st);
			result_t r;
			r.status = st;
			r.read_byte = 8'h00;
			r.last = 1'b1;
			r.cursor_pos = gbe_pkg::LW'(cursor);
			r.text_length = gbe_pkg::LW'(text_len);
			return r;
		endfunction

		// Accepted command: update the text and queue what it must produce
		function void note_command(command_t c);
			int target;
			int first;
			int n;
			result_t r;
			case (c.kind)
				gbe_pkg::K_INSERT: begin
					if (text_len >= gbe_pkg::CAPACITY) begin
						pending_results.push_back(status_only(gbe_pkg::ST_FULL));
					end else begin
						store_mem[cursor] = c.data_byte;
						cursor++;
						text_len++;
						pending_results.push_back(status_only(gbe_pkg::ST_OK));
					end
				end
				gbe_pkg::K_MOVE_REL, gbe_pkg::K_MOVE_ABS: begin
					target = (c.kind == gbe_pkg::K_MOVE_REL) ? cursor + int'(c.delta) :
						int'(c.position);
					if (target < 0 || target > text_len) begin
						pending_results.push_back(status_only(gbe_pkg::ST_RANGE));
					end else begin
						shift_gap(target);
						pending_results.push_back(status_only(gbe_pkg::ST_OK));
					end
				end
				gbe_pkg::K_READ: begin
					first = int'(c.offset);
					n = int'(c.count);
					if (n == 0 || n > gbe_pkg::MAX_READ || first + n > text_len) begin
						pending_results.push_back(status_only(gbe_pkg::ST_RANGE));
					end else begin
						for (int i = 0; i < n; i++) begin
							r = status_only(gbe_pkg::ST_OK);
							r.read_byte = byte_at(first + i);
							r.last = (i == n - 1);
							pending_results.push_back(r);
						end
					end
				end
				gbe_pkg::K_CLEAR: begin
					text_len = 0;
					cursor = 0;
					pending_results.push_back(status_only(gbe_pkg::ST_OK));
				end
				default: begin
					pending_results.push_back(status_only(gbe_pkg::ST_RANGE));
				end
			endcase
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
						got);
			end
		endfunction

		// Result transfer: compare with the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with none expected, expected nothing, actual status %0d",
						$time, got.status);
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("read_byte", want.read_byte, got.read_byte);
			compare_field("last", want.last, got.last);
			compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
			compare_field("text_length", want.text_length, got.text_length);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   idle_cycles = 0;
	int   burst_left = 0;

	gap_text_model model = new();

	gbe_in_if  req_ch ();
	gbe_out_if rsp_ch ();

	gap_buffer_engine_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Transfer monitor: feeds the model and counts quiet cycles
	always @(posedge clk) begin
		result_t  got;
		command_t c;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = gbe_pkg::status_t'(rsp_ch.status);
				got.read_byte = rsp_ch.read_byte;
				got.last = rsp_ch.last;
				got.cursor_pos = rsp_ch.cursor_pos;
				got.text_length = rsp_ch.text_length;
				model.check_result(got);
			end
			if (req_ch.valid && req_ch.ready) begin
				c.kind = req_ch.kind;
				c.data_byte = req_ch.data_byte;
				c.delta = req_ch.delta;
				c.position = req_ch.position;
				c.offset = req_ch.offset;
				c.count = req_ch.count;
				model.note_command(c);
			end
			if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("gap_buffer_engine_core_test NOT OK");
		$finish;
	end

	// Result receiver: stretches of steady, random and bursty back-pressure
	initial begin
		int mode;
		int stretch;
		int hold;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			stretch = $urandom_range(20, 200);
			while (stretch > 0) begin
				@(negedge clk);
				stretch--;
				case (mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = $urandom_range(0, 1);
					default: begin
						if ($urandom_range(0, 9) == 0) begin
							hold = $urandom_range(1, 8);
							rsp_ch.ready = 1'b0;
							repeat (hold - 1) @(negedge clk);
							stretch -= hold - 1;
						end else begin
							rsp_ch.ready = 1'b1;
						end
					end
				endcase
			end
		end
	end

	function automatic command_t mk(logic [2:0] k, int data = 0, int dl = 0, int pos = 0,
			int off = 0, int cnt = 0);
		command_t c;
		c.kind = k;
		c.data_byte = 8'(data);
		c.delta = 14'(dl);
		c.position = gbe_pkg::LW'(pos);
		c.offset = 12'(off);
		c.count = gbe_pkg::CW'(cnt);
		return c;
	endfunction

	// Random command shaped by the current text: mostly legal, some refused
	function automatic command_t random_command();
		command_t c;
		int pick;
		int lo;
		int hi;
		int n;
		c.kind = gbe_pkg::K_INSERT;
		c.data_byte = 8'($urandom);
		c.delta = 14'($urandom);
		c.position = gbe_pkg::LW'($urandom);
		c.offset = 12'($urandom);
		c.count = gbe_pkg::CW'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40 || pick >= 94) begin
			c.kind = gbe_pkg::K_INSERT;
		end else if (pick < 55) begin
			c.kind = gbe_pkg::K_MOVE_REL;
			if ($urandom_range(0, 99) < 85) begin
				lo = (model.cursor > 64) ? model.cursor - 64 : 0;
				hi = (model.cursor + 64 < model.text_len) ? model.cursor + 64 : model.text_len;
				c.delta = 14'($urandom_range(lo, hi) - model.cursor);
			end
		end else if (pick < 65) begin
			c.kind = gbe_pkg::K_MOVE_ABS;
			if ($urandom_range(0, 99) < 85)
				c.position = gbe_pkg::LW'($urandom_range(0, model.text_len));
		end else if (pick < 90) begin
			c.kind = gbe_pkg::K_READ;
			if ($urandom_range(0, 99) < 85 && model.text_len > 0) begin
				n = $urandom_range(1, (model.text_len < gbe_pkg::MAX_READ) ?
					model.text_len : gbe_pkg::MAX_READ);
				c.count = gbe_pkg::CW'(n);
				c.offset = 12'($urandom_range(0, model.text_len - n));
			end
		end else if (pick == 90) begin
			c.kind = gbe_pkg::K_CLEAR;
		end else begin
			c.kind = gbe_pkg::K_CLEAR + 3'($urandom_range(1, 3));
		end
		return c;
	endfunction

	// Command sender: bursts of transfers separated by random gaps
	task automatic send_command(command_t c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_ch.kind = c.kind;
		req_ch.data_byte = c.data_byte;
		req_ch.delta = c.delta;
		req_ch.position = c.position;
		req_ch.offset = c.offset;
		req_ch.count = c.count;
		req_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		command_t directed [$];
		command_t edge_cmds [$];

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = gbe_pkg::K_INSERT;
		req_ch.data_byte = '0;
		req_ch.delta = '0;
		req_ch.position = '0;
		req_ch.offset = '0;
		req_ch.count = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty text, small edits, refused moves and reads, unknown kinds, clear
		directed = '{
			mk(gbe_pkg::K_READ, 0, 0, 0, 0, 1),
			mk(gbe_pkg::K_MOVE_REL, 0, -1),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, 0),
			mk(gbe_pkg::K_INSERT, 8'h00),
			mk(gbe_pkg::K_INSERT, 8'hFF),
			mk(gbe_pkg::K_INSERT, 8'hA5),
			mk(gbe_pkg::K_INSERT, 8'h5A),
			mk(gbe_pkg::K_MOVE_REL, 0, 0),
			mk(gbe_pkg::K_MOVE_REL, 0, -2),
			mk(gbe_pkg::K_INSERT, 8'h3C),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, 5),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, 6),
			mk(gbe_pkg::K_MOVE_REL, 0, 1),
			mk(gbe_pkg::K_READ, 0, 0, 0, 0, 5),
			mk(gbe_pkg::K_READ, 0, 0, 0, 1, 0),
			mk(gbe_pkg::K_READ, 0, 0, 0, 0, gbe_pkg::MAX_READ + 1),
			mk(gbe_pkg::K_READ, 0, 0, 0, 2, 4),
			mk(gbe_pkg::K_CLEAR + 3'd1),
			mk(gbe_pkg::K_CLEAR + 3'd2),
			mk(gbe_pkg::K_CLEAR + 3'd3),
			mk(gbe_pkg::K_CLEAR),
			mk(gbe_pkg::K_READ, 0, 0, 0, 0, 1),
			mk(gbe_pkg::K_INSERT, 8'h81),
			mk(gbe_pkg::K_READ, 0, 0, 0, 0, 1),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, 0)
		};
		foreach (directed[i])
			send_command(directed[i]);

		repeat (250)
			send_command(random_command());

		// Moves and reads at the edges of the store and of the delta range
		edge_cmds = '{
			mk(gbe_pkg::K_INSERT, 8'h11),
			mk(gbe_pkg::K_INSERT, 8'hEE),
			mk(gbe_pkg::K_READ, 0, 0, 0, gbe_pkg::CAPACITY - gbe_pkg::MAX_READ,
				gbe_pkg::MAX_READ),
			mk(gbe_pkg::K_READ, 0, 0, 0, gbe_pkg::CAPACITY - 1, 1),
			mk(gbe_pkg::K_READ, 0, 0, 0, 0, (1 << gbe_pkg::CW) - 1),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, 0),
			mk(gbe_pkg::K_MOVE_REL, 0, gbe_pkg::CAPACITY),
			mk(gbe_pkg::K_MOVE_REL, 0, -gbe_pkg::CAPACITY),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, gbe_pkg::CAPACITY),
			mk(gbe_pkg::K_MOVE_REL, 0, -8192),
			mk(gbe_pkg::K_MOVE_REL, 0, 8191),
			mk(gbe_pkg::K_MOVE_ABS, 0, 0, gbe_pkg::CAPACITY / 2),
			mk(gbe_pkg::K_INSERT, 8'h77),
			mk(gbe_pkg::K_READ, 0, 0, 0, gbe_pkg::CAPACITY / 2 - gbe_pkg::MAX_READ / 2,
				gbe_pkg::MAX_READ),
			mk(gbe_pkg::K_MOVE_REL, 0, -gbe_pkg::CAPACITY),
			mk(gbe_pkg::K_CLEAR)
		};
		foreach (edge_cmds[i])
			send_command(edge_cmds[i]);

		repeat (250)
			send_command(random_command());
		req_ch.valid = 1'b0;

		// Drain, then watch for stray results
		while (model.pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (model.errors == 0 && model.pending_results.size() == 0)
			$display("gap_buffer_engine_core_test OK");
		else
			$display("gap_buffer_engine_core_test NOT OK");
		$finish;
	end

endmodule
